/* hdl/hte_pkg.sv */
`timescale 1ns / 1ps
// Shared types, field layout and helper functions for the Huffman table encoder.
// Used by hte_ctrl, hte_datapath and huffman_table_encoder_packer_unit; depends on nothing.

package hte_pkg;

    // Default sizes for the top-level parameters
    localparam int SYMBOL_COUNT_DEF    = 256;
    localparam int MAX_CODE_LENGTH_DEF = 64;

    // Input field widths
    localparam int CMD_W  = 2;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 64;
    localparam int LEN_W  = 7;

    // Input tdata layout, lowest field first; cmd travels alone in tuser
    localparam int SYM_LSB    = 0;
    localparam int CODE_LSB   = SYM_LSB + SYM_W;
    localparam int LEN_LSB    = CODE_LSB + CODE_W;
    localparam int IN_BITS    = LEN_LSB + LEN_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Output fields and tdata layout
    localparam int BYTE_W      = 8;
    localparam int PAD_W       = 3;
    localparam int PAD_LSB     = BYTE_W;
    localparam int OUT_BITS    = BYTE_W + PAD_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Pending bits held between items (at most seven)
    localparam int PEND_W = 7;
    localparam int CNT_W  = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_CODE = 1'b1;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_BIT_ORDER = 1'b0;  // register index bit paddr[2]

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // input transaction taken this cycle
        logic lookup;      // move table read data into the shift register
        logic step;        // pack one slice of code bits
        logic emit_err;    // emit the no-entry error result
        logic emit_flush;  // emit the padded final byte
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hit;         // looked-up symbol has a table entry
        logic rem_done;    // current step consumes the last code bit
        logic out_free;    // output register can take a result now
        logic pend_empty;  // no bits pending in the accumulator
    } dp_stat_t;

    // Mirror a byte end to end
    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7-i] = v[i];
        end
        return r;
    endfunction

endpackage

/* hdl/hte_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing controller of the Huffman table encoder: input handshake and item steps.
// Depends on hte_pkg for command codes and the command/status structs.

module hte_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [hte_pkg::CMD_W-1:0] in_cmd,
    input  hte_pkg::dp_stat_t         stat,
    output hte_pkg::dp_cmd_t          cmd
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_LOOKUP,
        S_RUN,
        S_ERR,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Take a new item only between items
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;

    // Next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.capture    = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        hte_pkg::CMD_ENCODE: state_next = S_LOOKUP;
                        hte_pkg::CMD_FLUSH:  state_next = S_FLUSH;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                if (stat.hit)
                begin
                    cmd.lookup = 1'b1;
                    state_next = S_RUN;
                end
                else
                begin
                    state_next = S_ERR;
                end
            end
            S_RUN:
            begin
                if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.rem_done)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (stat.pend_empty)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Lookup follows an accepted transaction directly
    a_lookup_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP) |-> $past(accept))
        else $error("lookup state entered without an accepted transaction");

    // Never more than one datapath action per cycle
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.lookup, cmd.step, cmd.emit_err, cmd.emit_flush}))
        else $error("conflicting datapath commands");

endmodule

/* hdl/hte_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the Huffman table encoder: code/length tables, entry valid bits,
// code shift register, bit accumulator and output register. Depends on hte_pkg.

module hte_datapath
#(
    parameter int SYMBOL_COUNT    = hte_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LENGTH = hte_pkg::MAX_CODE_LENGTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [hte_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [hte_pkg::CMD_W-1:0]       s_tuser,
    input  logic                            bit_order,
    input  hte_pkg::dp_cmd_t                cmd,
    output hte_pkg::dp_stat_t               stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hte_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int IW = $clog2(SYMBOL_COUNT);
    localparam int LW = $clog2(MAX_CODE_LENGTH + 1);
    localparam int ML = MAX_CODE_LENGTH;

    // Input fields
    logic [hte_pkg::CMD_W-1:0]  in_cmd;
    logic [hte_pkg::SYM_W-1:0]  symbol;
    logic [hte_pkg::CODE_W-1:0] code_bits;
    logic [hte_pkg::LEN_W-1:0]  code_length;

    assign in_cmd      = s_tuser;
    assign symbol      = s_tdata[hte_pkg::SYM_LSB  +: hte_pkg::SYM_W];
    assign code_bits   = s_tdata[hte_pkg::CODE_LSB +: hte_pkg::CODE_W];
    assign code_length = s_tdata[hte_pkg::LEN_LSB  +: hte_pkg::LEN_W];

    // Tables and valid bits
    logic [ML-1:0]           code_mem [SYMBOL_COUNT];
    logic [LW-1:0]           len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] entry_valid_reg;
    logic [ML-1:0]           code_rd_reg;
    logic [LW-1:0]           len_rd_reg;
    logic                    hit_reg;

    logic [IW-1:0]              idx;
    logic                       in_range;
    logic                       load_wr;
    logic                       enc_rd;
    logic [hte_pkg::LEN_W-1:0]  len_sat;
    logic [hte_pkg::CODE_W-1:0] code_shifted;
    logic [ML-1:0]              code_store;

    // Packing state
    logic [ML-1:0]              code_reg;
    logic [LW-1:0]              rem_reg;
    logic [hte_pkg::PEND_W-1:0] pend_reg;
    logic [hte_pkg::CNT_W-1:0]  cnt_reg;

    logic [3:0]    avail;
    logic [3:0]    take;
    logic [3:0]    sum;
    logic [7:0]    top8;
    logic [7:0]    merged;
    logic [7:0]    flush_byte;
    logic [LW-1:0] rem_after;
    logic          full;
    logic          emit_step;

    // Output register
    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg;
    logic [7:0]                 out_byte_next;
    logic                       status_reg;
    logic                       status_next;
    logic [hte_pkg::PAD_W-1:0]  pad_reg;
    logic [hte_pkg::PAD_W-1:0]  pad_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       out_load;
    logic                       out_free;

    // Code table access
    assign idx      = symbol[IW-1:0];
    assign in_range = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
    assign load_wr  = cmd.capture && (in_cmd == hte_pkg::CMD_LOAD) && in_range;
    assign enc_rd   = cmd.capture && (in_cmd == hte_pkg::CMD_ENCODE);

    // Saturate the length and left-align the code; high bits shift out
    assign len_sat      = (code_length > 7'(ML)) ? 7'(ML) : code_length;
    assign code_shifted = code_bits << (7'd64 - len_sat);
    assign code_store   = code_shifted[hte_pkg::CODE_W-1 -: ML];

    // Write and read the tables
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            code_mem[idx] <= code_store;
            len_mem[idx]  <= len_sat[LW-1:0];
        end
        if (enc_rd)
        begin
            code_rd_reg <= code_mem[idx];
            len_rd_reg  <= len_mem[idx];
        end
    end

    // Track written entries and the lookup hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            hit_reg         <= 1'b0;
        end
        else
        begin
            if (load_wr)
            begin
                entry_valid_reg[idx] <= 1'b1;
            end
            if (enc_rd)
            begin
                hit_reg <= in_range && entry_valid_reg[idx];
            end
        end
    end

    // Fill the pending byte from the top of the code, up to eight bits a cycle while the output register is free
    assign avail      = 4'd8 - {1'b0, cnt_reg};
    assign take       = (rem_reg < LW'(avail)) ? rem_reg[3:0] : avail;
    assign top8       = code_reg[ML-1 -: 8];
    assign merged     = {pend_reg, 1'b0} | (top8 >> cnt_reg);
    assign sum        = {1'b0, cnt_reg} + take;
    assign full       = sum[3];
    assign rem_after  = rem_reg - LW'(take);
    assign emit_step  = cmd.step && full;
    assign flush_byte = {pend_reg, 1'b0};

    // Advance the code shift register
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            code_reg <= code_rd_reg;
            rem_reg  <= len_rd_reg;
        end
        else if (cmd.step)
        begin
            code_reg <= code_reg << take;
            rem_reg  <= rem_after;
        end
    end

    // Hold the pending bits between items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.step)
        begin
            if (full)
            begin
                pend_reg <= '0;
                cnt_reg  <= '0;
            end
            else
            begin
                pend_reg <= merged[7:1];
                cnt_reg  <= sum[hte_pkg::CNT_W-1:0];
            end
        end
        else if (cmd.emit_flush)
        begin
            pend_reg <= '0;
            cnt_reg  <= '0;
        end
    end

    // Select the next result
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = emit_step || cmd.emit_err || cmd.emit_flush;

    always_comb
    begin
        out_byte_next = '0;
        status_next   = hte_pkg::STATUS_OK;
        pad_next      = '0;
        last_next     = 1'b1;
        if (cmd.emit_err)
        begin
            status_next = hte_pkg::STATUS_NO_CODE;
        end
        else if (cmd.emit_flush)
        begin
            out_byte_next = bit_order ? hte_pkg::reverse8(flush_byte) : flush_byte;
            pad_next      = 3'(4'd8 - {1'b0, cnt_reg});
        end
        else
        begin
            out_byte_next = bit_order ? hte_pkg::reverse8(merged) : merged;
            last_next     = (rem_after < LW'(8));
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= out_byte_next;
            status_reg   <= status_next;
            pad_reg      <= pad_next;
            last_reg     <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(hte_pkg::OUT_TDATA_W - hte_pkg::OUT_BITS){1'b0}}, pad_reg, out_byte_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    assign stat.hit        = hit_reg;
    assign stat.rem_done   = (rem_after == '0);
    assign stat.out_free   = out_free;
    assign stat.pend_empty = (cnt_reg == '0);

    // A result is only loaded into a free output register
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result loaded over an untaken result");

    // Flush leaves no pending bits
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_flush |=> (cnt_reg == '0) && (pend_reg == '0))
        else $error("pending bits survive a flush");

    // Error results carry a zero byte and close their item
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == hte_pkg::STATUS_NO_CODE)) |->
            ((out_byte_reg == '0) && last_reg && (pad_reg == '0)))
        else $error("malformed error result");

endmodule

/* hdl/huffman_table_encoder_packer_unit.sv */
`timescale 1ns / 1ps
// Top level of the Huffman table encoder and bit packer: configuration register
// and the controller/datapath pair. Depends on hte_pkg, hte_ctrl and hte_datapath.
//
//  Channel   Direction  Contents
//  s_*       in         item: cmd in s_tuser; symbol, code_bits, code_length in s_tdata
//  m_*       out        result: out_byte, pad_bits in m_tdata; status in m_tuser; last in m_tlast
//  APB       in/out     register 0 at byte 0: bit_order in bit 0
//
// A load is written as it is accepted. An encode passes an accept, a table read and one
// packing step per output byte slice, max(1, ceil((pending + length) / 8)) slices; the packer
// handles one byte slice per cycle while the output register is free. A flush passes an accept
// and, with bits pending, an emit; an encode without a table entry an accept, a table read and
// an error emit. A full output register stalls packing until m_tready. Reset clears the entry
// valid bits, the accumulator and bit_order at once; table contents are undefined until loaded.

module huffman_table_encoder_packer_unit
#(
    parameter int SYMBOL_COUNT    = hte_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LENGTH = hte_pkg::MAX_CODE_LENGTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // symbol[7:0], code_bits[71:8], code_length[78:72], zeros above
    input  logic [hte_pkg::IN_TDATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [hte_pkg::CMD_W-1:0]       s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // out_byte[7:0], pad_bits[10:8], zeros above
    output logic [hte_pkg::OUT_TDATA_W-1:0] m_tdata,
    // status[0]
    output logic                            m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hte_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hte_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hte_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic              bit_order_reg;
    logic              cfg_wr;
    hte_pkg::dp_cmd_t  dp_cmd;
    hte_pkg::dp_stat_t dp_stat;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == hte_pkg::REG_BIT_ORDER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_order_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            bit_order_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == hte_pkg::REG_BIT_ORDER) ?
                    {{(hte_pkg::APB_DATA_W - 1){1'b0}}, bit_order_reg} : '0;

    // Sequencing
    hte_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (s_tuser),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // Tables, packer and output register
    hte_datapath
    #(
        .SYMBOL_COUNT    (SYMBOL_COUNT),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .bit_order (bit_order_reg),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* dv/huffman_table_encoder_packer_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for huffman_table_encoder_packer_unit: table loads, symbol
// encodes and flushes on the input stream, the packed byte stream checked on the output.
// Depends on hte_pkg and the encoder RTL; needs no files or arguments.

module huffman_table_encoder_packer_unit_tb;
    import hte_pkg::*;

    localparam logic [CMD_W-1:0]      CMD_UNUSED     = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_BIT_ORDER = {REG_BIT_ORDER, 2'b00};
    localparam int                    SYMBOLS        = SYMBOL_COUNT_DEF;
    localparam int                    MAX_LEN        = MAX_CODE_LENGTH_DEF;
    // an encode of a 64-bit code on top of pending bits finishes well inside this
    localparam int                    SETTLE_CYCLES  = 24;

    // One output transaction as the encoder should present it
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              status;
        logic [PAD_W-1:0]  pad_bits;
        logic              last;
    } enc_result_t;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic [CMD_W-1:0]        s_tuser  = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tuser;
    logic                    m_tlast;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // Shadow of the encoder state
    logic [CODE_W-1:0]  code_mem [SYMBOLS];
    logic [LEN_W-1:0]   len_mem  [SYMBOLS];
    logic               entry_ok [SYMBOLS];
    logic [PEND_W-1:0]  pend_bits;
    logic [CNT_W-1:0]   pend_cnt;
    logic               order_lsb;
    int                 loaded_syms [$];

    enc_result_t        pending_results [$];
    int                 err_count     = 0;
    int                 send_idle_pct = 18;
    int                 recv_idle_pct = 48;

    huffman_table_encoder_packer_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Stall the output stream at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Map a stream-ordered byte (first bit in bit 0) to the configured packing
    function automatic logic [BYTE_W-1:0] stream_to_byte(input logic [BYTE_W-1:0] s);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = s[BYTE_W-1-i];
        end
        return order_lsb ? s : r;
    endfunction

    function automatic enc_result_t make_result(input logic [BYTE_W-1:0] b, input logic st,
                                                input logic [PAD_W-1:0] pad);
        enc_result_t r;
        r          = '0;
        r.out_byte = b;
        r.status   = st;
        r.pad_bits = pad;
        return r;
    endfunction

    // Advance the shadow state by one accepted item and queue its results
    function automatic void predict_encoder(input logic [CMD_W-1:0] cmd,
                                            input logic [SYM_W-1:0] sym,
                                            input logic [CODE_W-1:0] bits,
                                            input logic [LEN_W-1:0] len);
        enc_result_t       res [$];
        logic [BYTE_W-1:0] acc;
        logic [CODE_W-1:0] code;
        int                cnt;
        int                clen;
        case (cmd)
            CMD_LOAD:
            begin
                clen = (int'(len) > MAX_LEN) ? MAX_LEN : int'(len);
                code = bits;
                if (clen < CODE_W)
                    code = bits & ((64'd1 << clen) - 64'd1);
                code_mem[sym] = code;
                len_mem[sym]  = LEN_W'(clen);
                if (!entry_ok[sym])
                    loaded_syms.push_back(int'(sym));
                entry_ok[sym] = 1'b1;
            end
            CMD_ENCODE:
            begin
                if (!entry_ok[sym])
                begin
                    res.push_back(make_result('0, STATUS_NO_CODE, '0));
                end
                else
                begin
                    acc  = {1'b0, pend_bits};
                    cnt  = int'(pend_cnt);
                    clen = int'(len_mem[sym]);
                    code = code_mem[sym];
                    // shift in root bit first, emit each full byte
                    for (int i = clen; i > 0; i--)
                    begin
                        acc[cnt] = code[i-1];
                        cnt++;
                        if (cnt == BYTE_W)
                        begin
                            res.push_back(make_result(stream_to_byte(acc), STATUS_OK, '0));
                            acc = '0;
                            cnt = 0;
                        end
                    end
                    pend_bits = acc[PEND_W-1:0];
                    pend_cnt  = CNT_W'(cnt);
                end
            end
            CMD_FLUSH:
            begin
                if (pend_cnt != 0)
                    res.push_back(make_result(stream_to_byte({1'b0, pend_bits}), STATUS_OK,
                                              PAD_W'(BYTE_W - int'(pend_cnt))));
                pend_bits = '0;
                pend_cnt  = '0;
            end
            default:
            begin
            end
        endcase
        if (res.size() > 0)
            res[res.size()-1].last = 1'b1;
        foreach (res[k])
            pending_results.push_back(res[k]);
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, what, want, got);
            err_count++;
        end
    endfunction

    // Compare each output transaction with the oldest expected result
    always @(posedge clk)
    begin : check_results
        enc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none actual tdata %h tuser %b tlast %b",
                         $time, m_tdata, m_tuser, m_tlast);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_byte", want.out_byte, m_tdata[BYTE_W-1:0]);
                check_field("status", {7'b0, want.status}, {7'b0, m_tuser});
                check_field("pad_bits", {5'b0, want.pad_bits},
                            {5'b0, m_tdata[PAD_LSB +: PAD_W]});
                check_field("last", {7'b0, want.last}, {7'b0, m_tlast});
            end
        end
    end

    // Send one item, idling at random first; valid stays high until the next idle
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
        logic [IN_TDATA_W-1:0] word;
        word                       = '0;
        word[SYM_LSB  +: SYM_W]    = sym;
        word[CODE_LSB +: CODE_W]   = bits;
        word[LEN_LSB  +: LEN_W]    = len;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        predict_encoder(cmd, sym, bits, len);
    endtask

    // Drop valid, wait for every expected result, then let trailing work finish
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write bit_order through the APB port
    task automatic write_bit_order(input logic value);
        logic [APB_DATA_W-1:0] word;
        word    = '0;
        word[0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BIT_ORDER;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        order_lsb = value;
    endtask

    function automatic logic [LEN_W-1:0] random_code_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        if (pick < 70)
            return LEN_W'($urandom_range(12, 1));
        if (pick < 90)
            return LEN_W'($urandom_range(32, 13));
        if (pick < 97)
            return LEN_W'($urandom_range(64, 33));
        return LEN_W'($urandom_range(127, 65));
    endfunction

    // Mostly encodes of loaded symbols, with loads, flushes and some noise
    task automatic send_random_items(input int count);
        logic [CMD_W-1:0]  cmd;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        int                pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            bits = {$urandom, $urandom};
            sym  = SYM_W'($urandom_range(255));
            len  = random_code_length();
            if (pick < 60 && loaded_syms.size() > 0)
            begin
                cmd = CMD_ENCODE;
                sym = SYM_W'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
            end
            else if (pick < 80)
                cmd = CMD_LOAD;
            else if (pick < 84)
                cmd = CMD_ENCODE;
            else if (pick < 96)
                cmd = CMD_FLUSH;
            else
                cmd = CMD_UNUSED;
            send_item(cmd, sym, bits, len);
        end
    endtask

    // Field extremes and each special case, default most significant bit first packing
    task automatic test_directed_cases();
        // encode without an entry, empty flush, unused command
        send_item(CMD_ENCODE, 8'h5a, '0, '0);
        send_item(CMD_FLUSH, 8'h00, '0, '0);
        send_item(CMD_UNUSED, 8'hff, '1, '1);
        // zero-length code emits nothing
        send_item(CMD_LOAD, 8'h00, '1, 7'd0);
        send_item(CMD_ENCODE, 8'h00, '0, '0);
        // full 64-bit code, then a saturated length
        send_item(CMD_LOAD, 8'hff, '1, 7'd64);
        send_item(CMD_ENCODE, 8'hff, '0, '0);
        send_item(CMD_LOAD, 8'h01, {$urandom, $urandom}, 7'h7f);
        send_item(CMD_ENCODE, 8'h01, '0, '0);
        // short code with junk above its length; no-entry encode keeps pending bits
        send_item(CMD_LOAD, 8'h02, 64'hffff_ffff_ffff_fffd, 7'd3);
        send_item(CMD_ENCODE, 8'h02, '0, '0);
        send_item(CMD_ENCODE, 8'hc3, '0, '0);
        send_item(CMD_ENCODE, 8'h02, '0, '0);
        send_item(CMD_ENCODE, 8'h02, '0, '0);
        // overwrite an entry, then flush a partial byte
        send_item(CMD_LOAD, 8'h02, 64'h0, 7'd1);
        send_item(CMD_ENCODE, 8'h02, '0, '0);
        send_item(CMD_FLUSH, 8'h00, '0, '0);
        // seven pending bits give a single pad bit
        send_item(CMD_LOAD, 8'h80, 64'h55, 7'd7);
        send_item(CMD_ENCODE, 8'h80, '0, '0);
        send_item(CMD_FLUSH, 8'h00, '0, '0);
        // root bit only set, on top of pending bits
        send_item(CMD_LOAD, 8'h7f, 64'h8000_0000_0000_0000, 7'd64);
        send_item(CMD_ENCODE, 8'h80, '0, '0);
        send_item(CMD_ENCODE, 8'h7f, '0, '0);
        send_item(CMD_FLUSH, 8'h00, '0, '0);
        drain_outputs();
    endtask

    task automatic test_random_lsb_first();
        send_idle_pct = 18;
        recv_idle_pct = 48;
        write_bit_order(1'b1);
        send_random_items(62);
        drain_outputs();
    endtask

    task automatic test_random_msb_first();
        send_idle_pct = 48;
        recv_idle_pct = 18;
        write_bit_order(1'b0);
        send_random_items(62);
        drain_outputs();
    endtask

    task automatic test_random_back_to_back();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_bit_order(1'b1);
        send_random_items(62);
        drain_outputs();
    endtask

    initial
    begin
        for (int k = 0; k < SYMBOLS; k++)
        begin
            entry_ok[k] = 1'b0;
        end
        pend_bits = '0;
        pend_cnt  = '0;
        order_lsb = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_lsb_first();
        test_random_msb_first();
        test_random_back_to_back();

        if (err_count == 0)
            $display("huffman_table_encoder_packer_unit verification clean");
        else
            $display("huffman_table_encoder_packer_unit verification failed");
        $finish;
    end

    // Hard stop if the stream hangs
    initial
    begin
        #5_000_000;
        $display("huffman_table_encoder_packer_unit verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/hte_pkg.sv
hdl/hte_ctrl.sv
hdl/hte_datapath.sv
hdl/huffman_table_encoder_packer_unit.sv
dv/huffman_table_encoder_packer_unit_tb.sv
